/* src/tvr_pkg.sv */
// shared types and constants of the two-axis velocity ramp
package tvr_pkg;

   localparam int unsigned MAX_WIDTH  = 21;
   localparam int unsigned STEP_WIDTH = 16;
   localparam int unsigned DMD_WIDTH  = 16;
   localparam int unsigned VEL_WIDTH  = 32;
   localparam int unsigned CSR_WIDTH  = 21;
   localparam int unsigned CSR_INDEX_WIDTH = 3;

   // snap-to-zero and emit threshold, Q16
   localparam int unsigned EPSILON_Q16 = 66;
   // full demand in Q1.14
   localparam int unsigned DEMAND_FULL  = 16384;
   localparam int unsigned DEMAND_SHIFT = 14;

   typedef enum logic [1:0] {
      CMD_DEMAND   = 2'd0,
      CMD_VEL_TICK = 2'd1,
      CMD_WATCHDOG = 2'd2
   } cmd_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MAX_LINEAR     = 3'd0,
      CSR_MAX_ANGULAR    = 3'd1,
      CSR_LIN_ACCEL_STEP = 3'd2,
      CSR_LIN_COAST_STEP = 3'd3,
      CSR_LIN_BRAKE_STEP = 3'd4,
      CSR_ROT_ACCEL_STEP = 3'd5,
      CSR_ROT_COAST_STEP = 3'd6,
      CSR_ROT_BRAKE_STEP = 3'd7
   } csr_index_type;

   // ramp settings of one axis
   typedef struct packed {
      logic [MAX_WIDTH-1:0]  vmax;
      logic [STEP_WIDTH-1:0] accel;
      logic [STEP_WIDTH-1:0] coast;
      logic [STEP_WIDTH-1:0] brake;
   } axis_cfg_type;

   localparam logic [MAX_WIDTH-1:0]  RST_MAX_LINEAR     = 21'd65536;
   localparam logic [MAX_WIDTH-1:0]  RST_MAX_ANGULAR    = 21'd131072;
   localparam logic [STEP_WIDTH-1:0] RST_LIN_ACCEL_STEP = 16'd262;
   localparam logic [STEP_WIDTH-1:0] RST_LIN_COAST_STEP = 16'd524;
   localparam logic [STEP_WIDTH-1:0] RST_LIN_BRAKE_STEP = 16'd1311;
   localparam logic [STEP_WIDTH-1:0] RST_ROT_ACCEL_STEP = 16'd917;
   localparam logic [STEP_WIDTH-1:0] RST_ROT_COAST_STEP = 16'd1180;
   localparam logic [STEP_WIDTH-1:0] RST_ROT_BRAKE_STEP = 16'd1704;

endpackage

/* src/tvr_req_if.sv */
// request channel: command beat with forward and turn demands
interface tvr_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [1:0]                              cmd;
   logic signed [tvr_pkg::DMD_WIDTH-1:0]    forward_demand;
   logic signed [tvr_pkg::DMD_WIDTH-1:0]    turn_demand;

   modport source (output valid, cmd, forward_demand, turn_demand, input ready);
   modport sink   (input valid, cmd, forward_demand, turn_demand, output ready);
endinterface

/* src/tvr_rsp_if.sv */
// response channel: linear and angular velocity beat
interface tvr_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [tvr_pkg::VEL_WIDTH-1:0]    linear_velocity;
   logic signed [tvr_pkg::VEL_WIDTH-1:0]    angular_velocity;

   modport source (output valid, linear_velocity, angular_velocity, input ready);
   modport sink   (input valid, linear_velocity, angular_velocity, output ready);
endinterface

/* src/tvr_axis.sv */
// one-axis ramp step: accelerate, brake or coast, snap, cap and saturate
module tvr_axis (
   input  logic signed [tvr_pkg::VEL_WIDTH-1:0] vel,
   input  logic signed [tvr_pkg::DMD_WIDTH-1:0] demand,
   input  tvr_pkg::axis_cfg_type                cfg,
   output logic signed [tvr_pkg::VEL_WIDTH-1:0] new_vel,
   output logic                                 moving
);

   localparam int unsigned WW = tvr_pkg::VEL_WIDTH + 2;
   localparam int unsigned MW = tvr_pkg::DEMAND_SHIFT + 1;
   localparam int unsigned SP = tvr_pkg::STEP_WIDTH + MW;
   localparam int unsigned LP = tvr_pkg::MAX_WIDTH + MW;

   localparam logic signed [tvr_pkg::DMD_WIDTH-1:0] D_HI =
      tvr_pkg::DMD_WIDTH'(tvr_pkg::DEMAND_FULL);
   localparam logic signed [tvr_pkg::DMD_WIDTH-1:0] D_LO = -D_HI;
   localparam logic signed [WW-1:0] EPS    = WW'(tvr_pkg::EPSILON_Q16);
   localparam logic signed [WW-1:0] SAT_HI = 34'sd2147483647;
   localparam logic signed [WW-1:0] SAT_LO = -34'sd2147483648;

   logic signed [tvr_pkg::DMD_WIDTH-1:0] d;
   logic                                 d_pos;
   logic                                 d_neg;
   logic [MW-1:0]                        d_mag;
   logic [SP-1:0]                        acc_p;
   logic [SP-1:0]                        brk_p;
   logic [LP-1:0]                        lim_p;
   logic signed [WW-1:0]                 v;
   logic signed [WW-1:0]                 acc_s;
   logic signed [WW-1:0]                 brk_s;
   logic signed [WW-1:0]                 lim_s;
   logic signed [WW-1:0]                 coast_s;
   logic signed [WW-1:0]                 nv;
   logic signed [WW-1:0]                 sat;

   // demand clamp to plus or minus full
   always_comb begin
      if (demand > D_HI) begin
         d = D_HI;
      end else if (demand < D_LO) begin
         d = D_LO;
      end else begin
         d = demand;
      end
   end

   assign d_pos = (d > 0);
   assign d_neg = d[tvr_pkg::DMD_WIDTH-1];
   assign d_mag = d_neg ? MW'(-d) : MW'(d);

   // magnitudes scaled by demand, truncated toward zero
   assign acc_p = SP'(cfg.accel) * SP'(d_mag);
   assign brk_p = SP'(cfg.brake) * SP'(d_mag);
   assign lim_p = LP'(cfg.vmax) * LP'(d_mag);

   assign acc_s   = $signed(WW'(acc_p[SP-1:tvr_pkg::DEMAND_SHIFT]));
   assign brk_s   = $signed(WW'(brk_p[SP-1:tvr_pkg::DEMAND_SHIFT]));
   assign lim_s   = $signed(WW'(lim_p[LP-1:tvr_pkg::DEMAND_SHIFT]));
   assign coast_s = $signed(WW'(cfg.coast));
   assign v       = $signed({{2{vel[tvr_pkg::VEL_WIDTH-1]}}, vel});

   always_comb begin
      nv = '0;
      if (d_pos) begin
         if (v < 0) begin
            nv = v + brk_s;
            if (nv > -EPS) nv = '0;
         end else begin
            nv = v + acc_s;
         end
         if (nv > lim_s) nv = lim_s;
      end else if (d_neg) begin
         if (v > 0) begin
            nv = v - brk_s;
            if (nv < EPS) nv = '0;
         end else begin
            nv = v - acc_s;
         end
         if (nv < -lim_s) nv = -lim_s;
      end else begin
         if (v > 0) begin
            nv = v - coast_s;
            if (nv < EPS) nv = '0;
         end else if (v < 0) begin
            nv = v + coast_s;
            if (nv > -EPS) nv = '0;
         end
      end
   end

   always_comb begin
      if (nv > SAT_HI) begin
         sat = SAT_HI;
      end else if (nv < SAT_LO) begin
         sat = SAT_LO;
      end else begin
         sat = nv;
      end
   end

   assign new_vel = sat[tvr_pkg::VEL_WIDTH-1:0];
   assign moving  = (sat > EPS) || (sat < -EPS);

endmodule

/* src/two_axis_velocity_ramp.sv */
// top level of the two-axis velocity ramp
// Ramps a linear and an angular velocity (signed Q16) toward held joystick
// demands (signed Q1.14, 16384 is full). A demand beat (cmd 0) stores both
// demands and marks them fresh; a watchdog beat (cmd 2) zeroes the demands
// if none arrived since the previous watchdog, then clears the fresh mark;
// a velocity tick (cmd 1) runs one ramp step per axis and sends a response
// beat only when either velocity's magnitude is above the epsilon. cmd 3
// is ignored. Every request beat is latched into an input register and, once
// the output register is empty or draining, worked by one short
// combinational ramp step per axis; a tick's response lands in the output
// register at the end of that cycle. One request beat is taken per clock while
// the consumer does not stall. Velocity and demand state is updated in that
// same cycle, so consecutive beats see each other's effect. While a response
// is held by a stalled consumer the block still takes one more request beat
// into its input register. Ramp settings are to be written through the csr
// port only while the block is idle; the block does not enforce this.
module two_axis_velocity_ramp (
   input  logic                                      clock,
   input  logic                                      reset,
   tvr_req_if.sink                                   req_bus,
   tvr_rsp_if.source                                 rsp_bus,
   input  logic                                      csr_we,
   input  logic [tvr_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [tvr_pkg::CSR_WIDTH-1:0]             csr_wdata
);

   // settings registers
   tvr_pkg::axis_cfg_type lin_cfg_ff;
   tvr_pkg::axis_cfg_type rot_cfg_ff;

   // input register
   logic                                   s1_valid_ff;
   logic [1:0]                             s1_cmd_ff;
   logic signed [tvr_pkg::DMD_WIDTH-1:0]   s1_fwd_ff;
   logic signed [tvr_pkg::DMD_WIDTH-1:0]   s1_turn_ff;

   // ramp state
   logic signed [tvr_pkg::VEL_WIDTH-1:0]   lin_vel_ff;
   logic signed [tvr_pkg::VEL_WIDTH-1:0]   lin_vel_in;
   logic signed [tvr_pkg::VEL_WIDTH-1:0]   rot_vel_ff;
   logic signed [tvr_pkg::VEL_WIDTH-1:0]   rot_vel_in;
   logic signed [tvr_pkg::DMD_WIDTH-1:0]   held_fwd_ff;
   logic signed [tvr_pkg::DMD_WIDTH-1:0]   held_fwd_in;
   logic signed [tvr_pkg::DMD_WIDTH-1:0]   held_turn_ff;
   logic signed [tvr_pkg::DMD_WIDTH-1:0]   held_turn_in;
   logic                                   fresh_ff;
   logic                                   fresh_in;

   // output register
   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   logic signed [tvr_pkg::VEL_WIDTH-1:0]   rsp_lin_ff;
   logic signed [tvr_pkg::VEL_WIDTH-1:0]   rsp_rot_ff;

   logic                                   advance;
   logic                                   fire;
   logic                                   is_tick;
   logic                                   is_watchdog;
   logic signed [tvr_pkg::VEL_WIDTH-1:0]   lin_next;
   logic signed [tvr_pkg::VEL_WIDTH-1:0]   rot_next;
   logic                                   lin_moving;
   logic                                   rot_moving;

   // input register moves on when the output slot is empty or being drained
   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign fire          = s1_valid_ff && advance;
   assign is_tick       = (s1_cmd_ff == tvr_pkg::CMD_VEL_TICK);
   assign is_watchdog   = (s1_cmd_ff == tvr_pkg::CMD_WATCHDOG);
   assign req_bus.ready = !s1_valid_ff || advance;

   // settings writes
   always_ff @(posedge clock) begin
      if (reset) begin
         lin_cfg_ff.vmax  <= tvr_pkg::RST_MAX_LINEAR;
         rot_cfg_ff.vmax  <= tvr_pkg::RST_MAX_ANGULAR;
         lin_cfg_ff.accel <= tvr_pkg::RST_LIN_ACCEL_STEP;
         lin_cfg_ff.coast <= tvr_pkg::RST_LIN_COAST_STEP;
         lin_cfg_ff.brake <= tvr_pkg::RST_LIN_BRAKE_STEP;
         rot_cfg_ff.accel <= tvr_pkg::RST_ROT_ACCEL_STEP;
         rot_cfg_ff.coast <= tvr_pkg::RST_ROT_COAST_STEP;
         rot_cfg_ff.brake <= tvr_pkg::RST_ROT_BRAKE_STEP;
      end else if (csr_we) begin
         case (csr_index)
            tvr_pkg::CSR_MAX_LINEAR: begin
               lin_cfg_ff.vmax <= csr_wdata[tvr_pkg::MAX_WIDTH-1:0];
            end
            tvr_pkg::CSR_MAX_ANGULAR: begin
               rot_cfg_ff.vmax <= csr_wdata[tvr_pkg::MAX_WIDTH-1:0];
            end
            tvr_pkg::CSR_LIN_ACCEL_STEP: begin
               lin_cfg_ff.accel <= csr_wdata[tvr_pkg::STEP_WIDTH-1:0];
            end
            tvr_pkg::CSR_LIN_COAST_STEP: begin
               lin_cfg_ff.coast <= csr_wdata[tvr_pkg::STEP_WIDTH-1:0];
            end
            tvr_pkg::CSR_LIN_BRAKE_STEP: begin
               lin_cfg_ff.brake <= csr_wdata[tvr_pkg::STEP_WIDTH-1:0];
            end
            tvr_pkg::CSR_ROT_ACCEL_STEP: begin
               rot_cfg_ff.accel <= csr_wdata[tvr_pkg::STEP_WIDTH-1:0];
            end
            tvr_pkg::CSR_ROT_COAST_STEP: begin
               rot_cfg_ff.coast <= csr_wdata[tvr_pkg::STEP_WIDTH-1:0];
            end
            tvr_pkg::CSR_ROT_BRAKE_STEP: begin
               rot_cfg_ff.brake <= csr_wdata[tvr_pkg::STEP_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // input register: valid under reset, payload loads on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         s1_cmd_ff  <= req_bus.cmd;
         s1_fwd_ff  <= req_bus.forward_demand;
         s1_turn_ff <= req_bus.turn_demand;
      end
   end

   // one ramp step per axis
   tvr_axis u_lin (
      .vel     (lin_vel_ff),
      .demand  (held_fwd_ff),
      .cfg     (lin_cfg_ff),
      .new_vel (lin_next),
      .moving  (lin_moving)
   );

   tvr_axis u_rot (
      .vel     (rot_vel_ff),
      .demand  (held_turn_ff),
      .cfg     (rot_cfg_ff),
      .new_vel (rot_next),
      .moving  (rot_moving)
   );

   // state update per command
   always_comb begin
      lin_vel_in   = lin_vel_ff;
      rot_vel_in   = rot_vel_ff;
      held_fwd_in  = held_fwd_ff;
      held_turn_in = held_turn_ff;
      fresh_in     = fresh_ff;
      if (fire) begin
         case (s1_cmd_ff)
            tvr_pkg::CMD_DEMAND: begin
               held_fwd_in  = s1_fwd_ff;
               held_turn_in = s1_turn_ff;
               fresh_in     = 1'b1;
            end
            tvr_pkg::CMD_VEL_TICK: begin
               lin_vel_in = lin_next;
               rot_vel_in = rot_next;
            end
            tvr_pkg::CMD_WATCHDOG: begin
               // stale demands drop to zero
               if (!fresh_ff) begin
                  held_fwd_in  = '0;
                  held_turn_in = '0;
               end
               fresh_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_vel_ff   <= '0;
         rot_vel_ff   <= '0;
         held_fwd_ff  <= '0;
         held_turn_ff <= '0;
         fresh_ff     <= 1'b0;
      end else begin
         lin_vel_ff   <= lin_vel_in;
         rot_vel_ff   <= rot_vel_in;
         held_fwd_ff  <= held_fwd_in;
         held_turn_ff <= held_turn_in;
         fresh_ff     <= fresh_in;
      end
   end

   // output register: data loads on every tick; valid is set by a tick that leaves either axis moving
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = fire && is_tick && (lin_moving || rot_moving);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && is_tick) begin
         rsp_lin_ff <= lin_next;
         rsp_rot_ff <= rot_next;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.linear_velocity  = rsp_lin_ff;
   assign rsp_bus.angular_velocity = rsp_rot_ff;

   // velocities only change on a velocity tick
   a_vel_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      fire && !is_tick |=> $stable(lin_vel_ff) && $stable(rot_vel_ff))
      else $error("velocity changed on a non-tick beat");

   // a watchdog with no fresh demands leaves both demands at zero
   a_watchdog_zeroes: assert property (@(posedge clock) disable iff (reset)
      fire && is_watchdog && !fresh_ff |=> held_fwd_ff == '0 && held_turn_ff == '0)
      else $error("stale demands survived a watchdog beat");

   // every watchdog clears the fresh mark
   a_watchdog_clears_fresh: assert property (@(posedge clock) disable iff (reset)
      fire && is_watchdog |=> !fresh_ff)
      else $error("fresh mark set after a watchdog beat");

   // a new response comes only from a velocity tick
   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fire && is_tick))
      else $error("response loaded without a velocity tick");

endmodule
